@@ rtl/rse_pkg.sv @@
// Shared types and constants for the RPN stack evaluator.
package rse_pkg;

  localparam int unsigned DATA_W = 32;

  // Token operation codes
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // Per-cell shift command
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD_UP   = 2'd1,
    CELL_LOAD_DOWN = 2'd2
  } cell_cmd_e;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/rse_cell.sv @@
// One stack entry: loads from the entry above (push) or below (pop) or holds.
module rse_cell (
  input  logic                           clk_i,
  input  rse_pkg::cell_cmd_e             cmd_i,
  input  logic [rse_pkg::DATA_W-1:0]     up_i,
  input  logic [rse_pkg::DATA_W-1:0]     down_i,
  output logic [rse_pkg::DATA_W-1:0]     val_o
);
  import rse_pkg::*;

  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] val_d;

  // next value select
  always_comb begin
    unique case (cmd_i)
      CELL_LOAD_UP:   val_d = up_i;
      CELL_LOAD_DOWN: val_d = down_i;
      default:        val_d = val_q;
    endcase
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

@@ rtl/rse_divider.sv @@
// Signed truncating divider, one quotient bit per cycle (restoring).
module rse_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rse_pkg::div_req_t req_i,
  output rse_pkg::div_rsp_t rsp_o
);
  import rse_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] mag_b_q, mag_b_d;
  logic              neg_q, neg_d;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              fits;

  // one restoring step
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign fits    = shifted >= {1'b0, mag_b_q};
  assign diff    = shifted - {1'b0, mag_b_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    mag_b_d = mag_b_q;
    neg_d   = neg_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      rem_d   = '0;
      quo_d   = req_i.dividend[DATA_W-1] ? (DATA_W'(0) - req_i.dividend) : req_i.dividend;
      mag_b_d = req_i.divisor[DATA_W-1] ? (DATA_W'(0) - req_i.divisor) : req_i.divisor;
      neg_d   = req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
    end else if (busy_q) begin
      rem_d = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    mag_b_q <= mag_b_d;
    neg_q   <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

@@ rtl/rpn_stack_evaluator_unit.sv @@
// Push/add/sub write the top cell directly; multiply writes its registered product from S_MUL;
// divide waits in S_DIV (one quotient bit per cycle). Push/add/sub take one token per cycle
// unless stalled; mul and div hold off the input until the result is back in the top cell.
// A final token waits while an earlier result is held under stall; non-final tokens are taken.
// Reset clears stack pointer, error code, FSM and output valid; stack cells, answer and status are not.
// Stack of STACK_DEPTH cells, each shifting to its neighbor on push and pop.
module rpn_stack_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        operation_i,
  input  logic signed [rse_pkg::DATA_W-1:0] number_i,
  input  logic                              end_of_expression_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rse_pkg::DATA_W-1:0] answer_o,
  output logic [2:0]                        status_o
);
  import rse_pkg::*;

  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DIV  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  status_e           err_q, err_d;
  logic              last_q, last_d;
  logic [DATA_W-1:0] prod_q, prod_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] answer_q, answer_d;
  status_e           status_q, status_d;

  logic              in_acc;
  logic              finish;
  logic              push_en;
  logic              reduce_en;
  logic [DATA_W-1:0] new_top;
  logic [DATA_W-1:0] top_after;
  logic [DATA_W-1:0] first_op;
  logic [DATA_W-1:0] second_op;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [DATA_W-1:0] cell_val [STACK_DEPTH];
  cell_cmd_e         cmd_top;
  cell_cmd_e         cmd_rest;
  status_e           err_tok;
  logic [SP_W-1:0]   sp_tok;

  // input handshake
  assign in_stall_o = (state_q != S_IDLE) |
                      (out_valid_q & out_stall_i & end_of_expression_i);
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign second_op = cell_val[0];
  assign first_op  = cell_val[1];

  // token sequencing
  always_comb begin
    state_d          = state_q;
    sp_d             = sp_q;
    err_d            = err_q;
    last_d           = last_q;
    prod_d           = prod_q;
    push_en          = 1'b0;
    reduce_en        = 1'b0;
    new_top          = number_i;
    finish           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = first_op;
    div_req.divisor  = second_op;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          finish = end_of_expression_i;
          last_d = end_of_expression_i;
          if (err_q == ST_OK) begin
            case (op_e'(operation_i)) inside
              OP_PUSH: begin
                if (sp_q == SP_W'(STACK_DEPTH)) begin
                  err_d = ST_OVERFLOW;
                end else begin
                  push_en = 1'b1;
                  sp_d    = sp_q + SP_W'(1);
                end
              end
              OP_ADD, OP_SUB: begin
                if (sp_q < SP_W'(2)) begin
                  err_d = ST_UNDERFLOW;
                end else begin
                  reduce_en = 1'b1;
                  new_top   = (op_e'(operation_i) == OP_ADD) ? first_op + second_op
                                                              : first_op - second_op;
                  sp_d      = sp_q - SP_W'(1);
                end
              end
              OP_MUL: begin
                if (sp_q < SP_W'(2)) begin
                  err_d = ST_UNDERFLOW;
                end else begin
                  prod_d  = first_op * second_op;
                  state_d = S_MUL;
                  finish  = 1'b0;
                end
              end
              OP_DIV: begin
                if (sp_q < SP_W'(2)) begin
                  err_d = ST_UNDERFLOW;
                end else if (second_op == '0) begin
                  err_d = ST_DIVZERO;
                end else begin
                  div_req.start = 1'b1;
                  state_d       = S_DIV;
                  finish        = 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_MUL: begin
        reduce_en = 1'b1;
        new_top   = prod_q;
        sp_d      = sp_q - SP_W'(1);
        finish    = last_q;
        state_d   = S_IDLE;
      end
      S_DIV: begin
        new_top = div_rsp.quotient;
        if (div_rsp.done) begin
          reduce_en = 1'b1;
          sp_d      = sp_q - SP_W'(1);
          finish    = last_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (finish) begin
      sp_d  = '0;
      err_d = ST_OK;
    end
  end

  // error and stack pointer as left by the token, before the end-of-expression clear
  always_comb begin
    err_tok = err_q;
    sp_tok  = sp_q;
    if (state_q == S_IDLE) begin
      if (in_acc && err_q == ST_OK) begin
        if (op_e'(operation_i) == OP_PUSH) begin
          if (sp_q == SP_W'(STACK_DEPTH)) begin
            err_tok = ST_OVERFLOW;
          end else begin
            sp_tok = sp_q + SP_W'(1);
          end
        end else if (op_e'(operation_i) == OP_ADD || op_e'(operation_i) == OP_SUB ||
                     op_e'(operation_i) == OP_MUL || op_e'(operation_i) == OP_DIV) begin
          if (sp_q < SP_W'(2)) begin
            err_tok = ST_UNDERFLOW;
          end else if (op_e'(operation_i) == OP_DIV && second_op == '0) begin
            err_tok = ST_DIVZERO;
          end else begin
            sp_tok = sp_q - SP_W'(1);
          end
        end
      end
    end else begin
      sp_tok = sp_q - SP_W'(1);
    end
  end

  // result capture
  assign top_after = (push_en | reduce_en) ? new_top : cell_val[0];

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    answer_d    = answer_q;
    status_d    = status_q;
    if (finish) begin
      out_valid_d = 1'b1;
      if (err_tok != ST_OK) begin
        answer_d = '0;
        status_d = err_tok;
      end else if (sp_tok == '0) begin
        answer_d = '0;
        status_d = ST_EMPTY;
      end else begin
        answer_d = top_after;
        status_d = ST_OK;
      end
    end
  end

  // cell commands: push loads every cell from above; reduce writes the top, pops the rest
  assign cmd_top  = (push_en | reduce_en) ? CELL_LOAD_UP : CELL_HOLD;
  assign cmd_rest = push_en ? CELL_LOAD_UP : (reduce_en ? CELL_LOAD_DOWN : CELL_HOLD);

  // stack chain
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_val;
    logic [DATA_W-1:0] down_val;
    if (i == 0) begin : g_first
      assign up_val = new_top;
    end else begin : g_mid_up
      assign up_val = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_val = '0;
    end else begin : g_mid_down
      assign down_val = cell_val[i+1];
    end
    rse_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  ((i == 0) ? cmd_top : cmd_rest),
      .up_i   (up_val),
      .down_i (down_val),
      .val_o  (cell_val[i])
    );
  end

  // divide unit
  rse_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      err_q       <= ST_OK;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      err_q       <= err_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    answer_q <= answer_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = signed'(answer_q);
  assign status_o    = status_q;

  // stack pointer stays within the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // tokens are taken only when the sequencer is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (state_q == S_IDLE))
    else $error("token accepted while busy");

  // an error result carries a zero answer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_OK && status_q != ST_EMPTY) |-> (answer_q == '0))
    else $error("nonzero answer with error status");

  // divider completes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider done outside divide state");

  // a pending result is not overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(answer_q) && $stable(status_q)))
    else $error("stalled result changed");

endmodule

@@ verif/tb_rpn_stack_evaluator_unit.sv @@
// Self-checking testbench for the RPN stack evaluator: directed and random token streams.
module tb_rpn_stack_evaluator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rse_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned TOTAL_TOKENS = 1700;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 64;
  // Operation codes the block does not know
  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

  typedef struct {
    logic [31:0] answer;
    status_e     status;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [2:0]  operation = OP_PUSH;
  logic [31:0] number = '0;
  logic        end_mark = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] answer;
  logic [2:0]  status;

  // Predictor state
  logic [31:0] shadow_stack [STACK_DEPTH];
  int unsigned shadow_depth = 0;
  status_e     shadow_error = ST_OK;
  verdict_t    expected_verdicts [$];

  int unsigned errors_seen = 0;
  int unsigned sent_tokens = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_run = 0;
  int unsigned stall_mode = 0;

  rpn_stack_evaluator_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .operation_i        (operation),
    .number_i           (number),
    .end_of_expression_i(end_mark),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .answer_o           (answer),
    .status_o           (status)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Truncating signed division; -2^31 / -1 wraps back to -2^31
  function automatic logic [31:0] quotient_toward_zero(input logic [31:0] a,
                                                       input logic [31:0] b);
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] q;
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;
    q = mag_a / mag_b;
    if (a[31] ^ b[31]) q = -q;
    return q;
  endfunction

  // Apply one token to the shadow stack; queue the verdict on an end mark
  function automatic void evaluate_token(input logic [2:0] op, input logic [31:0] value,
                                         input logic last);
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] res;
    verdict_t    v;
    if (shadow_error == ST_OK) begin
      if (op == OP_PUSH) begin
        if (shadow_depth >= STACK_DEPTH) begin
          shadow_error = ST_OVERFLOW;
        end else begin
          shadow_stack[shadow_depth] = value;
          shadow_depth++;
        end
      end else if (op <= OP_DIV) begin
        if (shadow_depth < 2) begin
          shadow_error = ST_UNDERFLOW;
        end else begin
          rhs = shadow_stack[shadow_depth-1];
          lhs = shadow_stack[shadow_depth-2];
          res = '0;
          case (op)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) shadow_error = ST_DIVZERO;
              else res = quotient_toward_zero(lhs, rhs);
            end
          endcase
          if (shadow_error == ST_OK) begin
            shadow_stack[shadow_depth-2] = res;
            shadow_depth--;
          end
        end
      end
    end
    if (last) begin
      if (shadow_error != ST_OK) begin
        v.answer = '0;
        v.status = shadow_error;
      end else if (shadow_depth == 0) begin
        v.answer = '0;
        v.status = ST_EMPTY;
      end else begin
        v.answer = shadow_stack[shadow_depth-1];
        v.status = ST_OK;
      end
      expected_verdicts = {expected_verdicts, v};
      shadow_depth = 0;
      shadow_error = ST_OK;
    end
  endfunction

  // Send one item; bursts of back-to-back items separated by random gaps
  task automatic send_token(input logic [2:0] op, input logic [31:0] value, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    operation <= op;
    number    <= value;
    end_mark  <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    evaluate_token(op, value, last);
    sent_tokens++;
  endtask

  // Operand source biased toward corner values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return 32'(signed'($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_operator();
    return 3'($urandom_range(OP_ADD, OP_DIV));
  endfunction

  task automatic test_arithmetic();
    send_token(OP_PUSH, 32'd3, 1'b0);
    send_token(OP_PUSH, 32'd4, 1'b0);
    send_token(OP_ADD, $urandom, 1'b1);
    send_token(OP_PUSH, INT_MIN, 1'b0);
    send_token(OP_PUSH, 32'hffff_ffff, 1'b0);
    send_token(OP_DIV, '0, 1'b1);
    send_token(OP_PUSH, 32'd7, 1'b0);
    send_token(OP_PUSH, -32'sd2, 1'b0);
    send_token(OP_DIV, '0, 1'b1);
    send_token(OP_PUSH, -32'sd7, 1'b0);
    send_token(OP_PUSH, 32'd2, 1'b0);
    send_token(OP_DIV, '0, 1'b1);
    send_token(OP_PUSH, INT_MAX, 1'b0);
    send_token(OP_PUSH, 32'd2, 1'b0);
    send_token(OP_MUL, '0, 1'b1);
    send_token(OP_PUSH, INT_MIN, 1'b0);
    send_token(OP_PUSH, 32'd1, 1'b0);
    send_token(OP_SUB, '0, 1'b1);
    send_token(OP_PUSH, INT_MAX, 1'b0);
    send_token(OP_PUSH, 32'd1, 1'b0);
    send_token(OP_ADD, '0, 1'b1);
    send_token(OP_PUSH, 32'hffff_ffff, 1'b1);
  endtask

  task automatic test_error_codes();
    // underflow on the very first token
    send_token(OP_ADD, '0, 1'b1);
    // divide by zero, then later tokens are ignored
    send_token(OP_PUSH, 32'd5, 1'b0);
    send_token(OP_PUSH, 32'd0, 1'b0);
    send_token(OP_DIV, '0, 1'b0);
    send_token(OP_PUSH, 32'd3, 1'b0);
    send_token(OP_ADD, '0, 1'b1);
    // end on an unknown operation with nothing stacked
    send_token(OP_UNUSED_LO, INT_MAX, 1'b1);
    // unknown operations leave the stack alone
    send_token(OP_PUSH, 32'd9, 1'b0);
    send_token(OP_UNUSED_HI, '0, 1'b0);
    send_token(OP_UNUSED_MID, '0, 1'b1);
    // underflow is sticky over a later push
    send_token(OP_PUSH, 32'd1, 1'b0);
    send_token(OP_MUL, '0, 1'b0);
    send_token(OP_PUSH, 32'd2, 1'b1);
  endtask

  task automatic test_stack_limits();
    int unsigned i;
    // exactly full, then reduce to one entry
    for (i = 0; i < STACK_DEPTH; i++) send_token(OP_PUSH, pick_operand(), 1'b0);
    for (i = 1; i < STACK_DEPTH; i++) send_token(pick_operator(), '0, i == STACK_DEPTH - 1);
    // full stack, pop one, push again
    for (i = 0; i < STACK_DEPTH; i++) send_token(OP_PUSH, $urandom, 1'b0);
    send_token(OP_SUB, '0, 1'b0);
    send_token(OP_PUSH, INT_MIN, 1'b1);
    // one push too many
    for (i = 0; i <= STACK_DEPTH; i++) send_token(OP_PUSH, $urandom, 1'b0);
    send_token(OP_ADD, '0, 1'b1);
  endtask

  // Well-formed expression; a broken one may get a stray token, or a zero push and a divide, somewhere
  task automatic send_expression(input int unsigned operands, input bit broken);
    int unsigned depth;
    int unsigned pushed;
    int unsigned idx;
    int unsigned spoil_at;
    depth = 0;
    pushed = 0;
    idx = 0;
    spoil_at = broken ? $urandom_range(0, 2 * operands) : 4 * operands + 8;
    while (pushed < operands || depth > 1) begin
      if (idx == spoil_at) begin
        if ($urandom_range(0, 2) == 0) begin
          send_token(OP_PUSH, '0, 1'b0);
          send_token(OP_DIV, $urandom, 1'b0);
        end else begin
          send_token(3'($urandom_range(OP_ADD, OP_UNUSED_HI)), $urandom, 1'b0);
        end
      end
      if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
        send_token(OP_PUSH, pick_operand(), pushed + 1 == operands && depth == 0);
        pushed++;
        depth++;
      end else begin
        send_token(pick_operator(), $urandom, pushed == operands && depth == 2);
        depth--;
      end
      idx++;
    end
  endtask

  task automatic test_random_expressions();
    int unsigned kind;
    int unsigned n;
    int unsigned i;
    while (sent_tokens < TOTAL_TOKENS) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        send_expression(n, 1'b0);
      end else if (kind < 86) begin
        send_expression($urandom_range(1, 8), 1'b1);
      end else if (kind < 88) begin
        // deep stack, sometimes past the top
        n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 3);
        for (i = 0; i < n; i++) send_token(OP_PUSH, pick_operand(), 1'b0);
        for (i = 1; i < n; i++) send_token(pick_operator(), '0, i == n - 1);
      end else begin
        // noise: random tokens with an end mark at the close
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
          send_token(3'($urandom_range(OP_PUSH, OP_UNUSED_HI)), $urandom, i == n - 1);
        end
      end
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: answer %0d status %0d", $signed(answer), status);
        errors_seen++;
      end else begin
        v = expected_verdicts.pop_front();
        if (answer !== v.answer) begin
          $error("answer: expected %0d, got %0d", $signed(v.answer), $signed(answer));
          errors_seen++;
        end
        if (status !== v.status) begin
          $error("status: expected %0d, got %0d", v.status, status);
          errors_seen++;
        end
      end
    end
  end

  // Receiver stall pattern: free-flowing, choppy and mostly-stalled stretches
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_run  <= $urandom_range(10, 80);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_arithmetic();
    test_error_codes();
    test_stack_limits();
    test_random_expressions();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_verdicts.size() != 0) errors_seen++;
    if (errors_seen == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
